// ----- rtl/bcg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_pkg
// Shared types, constants and curve tables of the battery charge gauge.
// ----------------------------------------------------------------------------
package bcg_pkg;

  // microvolt magnitudes of the window and the divider remainder
  localparam int UV_W = 23;
  // signed open-circuit voltage in microvolts
  localparam int OCV_UV_W = 25;

  // ratio quotient bits and divider layout
  localparam int RATIO_W = 16;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = RATIO_W / DIV_BITS_PER_STAGE;

  // discharge curve
  localparam int CURVE_POINTS = 12;
  localparam int SEG_W = 4;
  localparam int PCT_STEP_MAX = 10;

  // register indexes
  localparam logic [1:0] CFG_FULL_MV  = 2'd0;
  localparam logic [1:0] CFG_EMPTY_MV = 2'd1;
  localparam logic [1:0] CFG_PATH_RES = 2'd2;

  // register reset values
  localparam logic [12:0] FULL_MV_RESET  = 13'd4200;
  localparam logic [12:0] EMPTY_MV_RESET = 13'd3300;
  localparam logic [9:0]  PATH_RES_RESET = 10'd320;

  // charge state codes
  localparam logic [2:0] CHG_PRE  = 3'd1;
  localparam logic [2:0] CHG_CC   = 3'd2;
  localparam logic [2:0] CHG_CV   = 3'd3;
  localparam logic [2:0] CHG_DONE = 3'd4;

  // scaling
  localparam int VBAT_UV_PER_CODE = 2000;
  localparam int UV_PER_MV = 1000;
  localparam logic [24:0] RECIP_MV = 25'd17179869;  // floor(2^34 / 1000)
  localparam int RECIP_SHIFT = 34;
  localparam int OCV_MAX_MV = 16383;
  localparam logic [16:0] RATIO_ONE = 17'd65536;
  localparam int NORM_LOW_Q8 = 844800;               // 3300 mV with 8 fraction bits
  localparam int NORM_SPAN_MV = 900;

  localparam logic [6:0] PCT_FULL = 7'd100;
  localparam logic [6:0] PCT_CHARGING_MAX = 7'd99;

  typedef struct packed {
    logic [7:0] vbat_low_byte;
    logic [7:0] vbat_high_byte;
    logic [7:0] ibat_low_byte;
    logic [7:0] ibat_high_byte;
    logic [7:0] charger_status_byte;
  } sample_t;

  typedef struct packed {
    logic signed [14:0] ocv_mv;
    logic [6:0]         percentage;
    logic               charging;
    logic               is_full;
  } result_t;

  typedef struct packed {
    logic [9:0]      path_res;
    logic [UV_W-1:0] empty_uv;
    logic [UV_W-1:0] den_uv;
    logic            window_ok;
  } gauge_cfg_t;

  // side information carried along the divider
  typedef struct packed {
    logic signed [14:0] ocv_mv;
    logic               charging;
    logic               is_full;
    logic               use_div;
    logic [RATIO_W:0]   ratio_fixed;
  } div_side_t;

  typedef struct packed {
    div_side_t       side;
    logic [UV_W-1:0] num_uv;
  } front_item_t;

  typedef struct packed {
    logic signed [14:0] ocv_mv;
    logic               charging;
    logic               is_full;
    logic [RATIO_W:0]   ratio;
  } ratio_item_t;

  function automatic logic [12:0] curve_mv(input logic [SEG_W-1:0] idx);
    case (idx)
      4'd0:    curve_mv = 13'd4200;
      4'd1:    curve_mv = 13'd4060;
      4'd2:    curve_mv = 13'd3980;
      4'd3:    curve_mv = 13'd3920;
      4'd4:    curve_mv = 13'd3870;
      4'd5:    curve_mv = 13'd3820;
      4'd6:    curve_mv = 13'd3790;
      4'd7:    curve_mv = 13'd3770;
      4'd8:    curve_mv = 13'd3740;
      4'd9:    curve_mv = 13'd3680;
      4'd10:   curve_mv = 13'd3450;
      4'd11:   curve_mv = 13'd3300;
      default: curve_mv = 13'd3300;
    endcase
  endfunction

  function automatic logic [6:0] curve_pct(input logic [SEG_W-1:0] idx);
    case (idx)
      4'd0:    curve_pct = 7'd100;
      4'd1:    curve_pct = 7'd90;
      4'd2:    curve_pct = 7'd80;
      4'd3:    curve_pct = 7'd70;
      4'd4:    curve_pct = 7'd60;
      4'd5:    curve_pct = 7'd50;
      4'd6:    curve_pct = 7'd40;
      4'd7:    curve_pct = 7'd30;
      4'd8:    curve_pct = 7'd20;
      4'd9:    curve_pct = 7'd10;
      4'd10:   curve_pct = 7'd5;
      4'd11:   curve_pct = 7'd0;
      default: curve_pct = 7'd0;
    endcase
  endfunction

endpackage

// ----- rtl/bcg_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_front
// Sample decode, IR drop correction, mV conversion and ratio window setup.
// ----------------------------------------------------------------------------
module bcg_front (
  input  logic                 clk,
  input  logic                 rst,
  input  bcg_pkg::gauge_cfg_t  cfg,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  bcg_pkg::sample_t     sample,
  output logic                 item_valid,
  input  logic                 item_stall,
  output bcg_pkg::front_item_t item
);

  logic v0, v1, v2, v3;
  logic hold0, hold1, hold2, hold3;

  // stage 0: decoded sample
  logic [11:0]        vcode0;
  logic signed [11:0] icode0;
  logic               chg0, full0;
  // stage 1: open-circuit voltage in uV
  logic signed [bcg_pkg::OCV_UV_W-1:0] ocv_uv1;
  logic                                chg1, full1;
  // stage 2: magnitude, reciprocal estimate, window decision
  logic [23:0]                  abs_uv2;
  logic                         neg2;
  logic [14:0]                  q0_2;
  logic                         chg2, full2, use_div2;
  logic [bcg_pkg::RATIO_W:0]    fixed2;
  logic [bcg_pkg::UV_W-1:0]     num2;
  // stage 3
  bcg_pkg::front_item_t item3;

  logic [2:0] chg_state;
  logic       present, chg_w, full_w;

  logic signed [13:0] ibat_ma;
  logic signed [10:0] res_s;
  logic signed [23:0] drop_uv;
  logic [22:0]        vbat_uv;
  logic signed [bcg_pkg::OCV_UV_W-1:0] ocv_uv_w;

  logic signed [bcg_pkg::OCV_UV_W-1:0] abs_full;
  logic [23:0]                  abs_w;
  logic [48:0]                  recip_prod;
  logic signed [25:0]           num_w;
  logic                         num_pos, num_ge_den, use_div_w;
  logic [bcg_pkg::RATIO_W:0]    fixed_w;

  logic [24:0] back_uv, rem_uv;
  logic [14:0] q_w, ocv_bits;

  // stall chain
  assign hold3 = v3 && item_stall;
  assign hold2 = v2 && hold3;
  assign hold1 = v1 && hold2;
  assign hold0 = v0 && hold1;
  assign sample_stall = hold0;

  // status decode
  always_comb begin
    chg_state = sample.charger_status_byte[5:3];
    present   = (sample.charger_status_byte[2:0] != 3'd0) || sample.charger_status_byte[6];
    chg_w     = present && ((chg_state == bcg_pkg::CHG_PRE) || (chg_state == bcg_pkg::CHG_CC) ||
                            (chg_state == bcg_pkg::CHG_CV));
    full_w    = present && (chg_state == bcg_pkg::CHG_DONE);
  end

  // vbat * 2000 - ibat * 4 * r
  always_comb begin
    ibat_ma  = {icode0, 2'b00};
    res_s    = $signed({1'b0, cfg.path_res});
    drop_uv  = 24'(ibat_ma) * 24'(res_s);
    vbat_uv  = 23'(vcode0) * 23'(bcg_pkg::VBAT_UV_PER_CODE);
    ocv_uv_w = $signed({2'b00, vbat_uv}) - {drop_uv[23], drop_uv};
  end

  // magnitude times reciprocal of 1000, window compares
  always_comb begin
    abs_full   = ocv_uv1[bcg_pkg::OCV_UV_W-1] ? -ocv_uv1 : ocv_uv1;
    abs_w      = abs_full[23:0];
    recip_prod = 49'(abs_w) * 49'(bcg_pkg::RECIP_MV);
    num_w      = 26'(ocv_uv1) - $signed({3'b000, cfg.empty_uv});
    num_pos    = !num_w[25] && (num_w != 26'sd0);
    num_ge_den = num_w >= $signed({3'b000, cfg.den_uv});
    use_div_w  = 1'b0;
    fixed_w    = '0;
    if (cfg.window_ok) begin
      if (!num_pos) begin
        fixed_w = '0;
      end else if (num_ge_den) begin
        fixed_w = bcg_pkg::RATIO_ONE;
      end else begin
        use_div_w = 1'b1;
      end
    end else begin
      fixed_w = num_w[25] ? '0 : bcg_pkg::RATIO_ONE;
    end
  end

  // estimate is at most one low: one compare fixes it
  always_comb begin
    back_uv  = 25'(q0_2) * 25'(bcg_pkg::UV_PER_MV);
    rem_uv   = 25'(abs_uv2) - back_uv;
    q_w      = q0_2 + 15'(rem_uv >= 25'(bcg_pkg::UV_PER_MV));
    if (neg2) begin
      ocv_bits = 15'd0 - q_w;
    end else if (q_w > 15'(bcg_pkg::OCV_MAX_MV)) begin
      ocv_bits = 15'(bcg_pkg::OCV_MAX_MV);
    end else begin
      ocv_bits = q_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (!hold0) v0 <= sample_valid;
      if (!hold1) v1 <= v0;
      if (!hold2) v2 <= v1;
      if (!hold3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold0) begin
      vcode0 <= {sample.vbat_high_byte[3:0], sample.vbat_low_byte};
      icode0 <= $signed({sample.ibat_high_byte[3:0], sample.ibat_low_byte});
      chg0   <= chg_w;
      full0  <= full_w;
    end
    if (!hold1) begin
      ocv_uv1 <= ocv_uv_w;
      chg1    <= chg0;
      full1   <= full0;
    end
    if (!hold2) begin
      abs_uv2  <= abs_w;
      neg2     <= ocv_uv1[bcg_pkg::OCV_UV_W-1];
      q0_2     <= recip_prod[bcg_pkg::RECIP_SHIFT +: 15];
      chg2     <= chg1;
      full2    <= full1;
      use_div2 <= use_div_w;
      fixed2   <= fixed_w;
      num2     <= num_w[bcg_pkg::UV_W-1:0];
    end
    if (!hold3) begin
      item3.side.ocv_mv      <= ocv_bits;
      item3.side.charging    <= chg2;
      item3.side.is_full     <= full2;
      item3.side.use_div     <= use_div2;
      item3.side.ratio_fixed <= fixed2;
      item3.num_uv           <= num2;
    end
  end

  assign item_valid = v3;
  assign item       = item3;

endmodule

// ----- rtl/bcg_ratio_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_ratio_div
// Pipelined restoring divider for the Q0.16 charge window ratio.
// ----------------------------------------------------------------------------
module bcg_ratio_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [bcg_pkg::UV_W-1:0] den_uv,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  bcg_pkg::front_item_t     in_item,
  output logic                     out_valid,
  input  logic                     out_stall,
  output bcg_pkg::ratio_item_t     out_item
);

  localparam int N = bcg_pkg::DIV_STAGES;
  localparam int W = bcg_pkg::UV_W;
  localparam int Q = bcg_pkg::RATIO_W;

  logic [N-1:0] vld, hold, vld_src;

  logic [W-1:0]       rem_q   [N];
  logic [Q-1:0]       quo_q   [N];
  bcg_pkg::div_side_t side_q  [N];
  logic [W-1:0]       rem_src [N];
  logic [Q-1:0]       quo_src [N];
  bcg_pkg::div_side_t side_src[N];
  logic [W-1:0]       rem_nx  [N];
  logic [Q-1:0]       quo_nx  [N];

  // stall chain from the last stage back
  always_comb begin
    hold[N-1] = vld[N-1] && out_stall;
    for (int k = N - 2; k >= 0; k--) begin
      hold[k] = vld[k] && hold[k+1];
    end
  end
  assign in_stall = hold[0];
  assign vld_src  = {vld[N-2:0], in_valid};

  // two quotient bits per stage
  always_comb begin
    logic [W:0]   trial;
    logic [W-1:0] r;
    logic [Q-1:0] qv;
    rem_src[0]  = in_item.num_uv;
    quo_src[0]  = '0;
    side_src[0] = in_item.side;
    for (int k = 1; k < N; k++) begin
      rem_src[k]  = rem_q[k-1];
      quo_src[k]  = quo_q[k-1];
      side_src[k] = side_q[k-1];
    end
    for (int k = 0; k < N; k++) begin
      r  = rem_src[k];
      qv = quo_src[k];
      for (int b = 0; b < bcg_pkg::DIV_BITS_PER_STAGE; b++) begin
        trial = {r, 1'b0};
        if (trial >= {1'b0, den_uv}) begin
          r  = W'(trial - {1'b0, den_uv});
          qv = {qv[Q-2:0], 1'b1};
        end else begin
          r  = trial[W-1:0];
          qv = {qv[Q-2:0], 1'b0};
        end
      end
      rem_nx[k] = r;
      quo_nx[k] = qv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (!hold[k]) vld[k] <= vld_src[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (!hold[k]) begin
        rem_q[k]  <= rem_nx[k];
        quo_q[k]  <= quo_nx[k];
        side_q[k] <= side_src[k];
      end
    end
  end

  assign out_valid         = vld[N-1];
  assign out_item.ocv_mv   = side_q[N-1].ocv_mv;
  assign out_item.charging = side_q[N-1].charging;
  assign out_item.is_full  = side_q[N-1].is_full;
  assign out_item.ratio    = side_q[N-1].use_div ? {1'b0, quo_q[N-1]}
                                                 : side_q[N-1].ratio_fixed;

endmodule

// ----- rtl/bcg_curve.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_curve
// Maps the ratio onto the curve voltage range and interpolates the percentage.
// ----------------------------------------------------------------------------
module bcg_curve (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bcg_pkg::ratio_item_t in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bcg_pkg::result_t     out_result
);

  localparam int SW = bcg_pkg::SEG_W;

  logic v0, v1, v2, v3;
  logic hold0, hold1, hold2, hold3;

  // flags and ocv ride along every stage
  logic signed [14:0] ocv0, ocv1, ocv2;
  logic               chg0, chg1, chg2, full0, full1, full2;

  logic [20:0]   norm0;
  logic [SW-1:0] seg1, seg2;
  logic [15:0]   x1;
  logic          top1, bot1, top2, bot2;
  logic [10:0]   y2;
  bcg_pkg::result_t res3;

  logic [25:0]   scaled;
  logic [20:0]   norm_w;
  logic [SW-1:0] seg_w;
  logic [20:0]   x_full;
  logic [6:0]    dp;
  logic [18:0]   xdp;
  logic [12:0]   d_full;
  logic [7:0]    d;
  logic [SW-1:0] q;
  logic [6:0]    pct_w, pct_out;

  assign hold3 = v3 && out_stall;
  assign hold2 = v2 && hold3;
  assign hold1 = v1 && hold2;
  assign hold0 = v0 && hold1;
  assign in_stall = hold0;

  // 3300 mV plus ratio times 900 mV, 8 fraction bits
  always_comb begin
    scaled = 26'(in_item.ratio) * 26'(bcg_pkg::NORM_SPAN_MV);
    norm_w = 21'(bcg_pkg::NORM_LOW_Q8) + {3'b000, scaled[25:8]};
  end

  // segment search over the descending curve
  always_comb begin
    seg_w = '0;
    for (int j = 1; j < bcg_pkg::CURVE_POINTS - 1; j++) begin
      seg_w = seg_w + SW'(norm0 <= {bcg_pkg::curve_mv(SW'(j)), 8'd0});
    end
    x_full = norm0 - {bcg_pkg::curve_mv(seg_w + SW'(1)), 8'd0};
  end

  always_comb begin
    dp  = bcg_pkg::curve_pct(seg1) - bcg_pkg::curve_pct(seg1 + SW'(1));
    xdp = 19'(x1) * 19'(dp);
  end

  // small quotient y / d by parallel threshold compares, up to a whole step
  // when the voltage sits exactly on the upper knee
  always_comb begin
    d_full = bcg_pkg::curve_mv(seg2) - bcg_pkg::curve_mv(seg2 + SW'(1));
    d      = d_full[7:0];
    q      = '0;
    for (int k = 1; k <= bcg_pkg::PCT_STEP_MAX; k++) begin
      if ({1'b0, y2} >= 12'(k) * {4'b0000, d}) q = q + SW'(1);
    end
    if (top2) begin
      pct_w = bcg_pkg::PCT_FULL;
    end else if (bot2) begin
      pct_w = '0;
    end else begin
      pct_w = bcg_pkg::curve_pct(seg2 + SW'(1)) + 7'(q);
    end
    if (full2) begin
      pct_out = bcg_pkg::PCT_FULL;
    end else if (chg2 && (pct_w == bcg_pkg::PCT_FULL)) begin
      pct_out = bcg_pkg::PCT_CHARGING_MAX;
    end else begin
      pct_out = pct_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (!hold0) v0 <= in_valid;
      if (!hold1) v1 <= v0;
      if (!hold2) v2 <= v1;
      if (!hold3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold0) begin
      norm0 <= norm_w;
      ocv0  <= in_item.ocv_mv;
      chg0  <= in_item.charging;
      full0 <= in_item.is_full;
    end
    if (!hold1) begin
      seg1  <= seg_w;
      x1    <= x_full[15:0];
      top1  <= norm0 >= {bcg_pkg::curve_mv(SW'(0)), 8'd0};
      bot1  <= norm0 <= {bcg_pkg::curve_mv(SW'(bcg_pkg::CURVE_POINTS - 1)), 8'd0};
      ocv1  <= ocv0;
      chg1  <= chg0;
      full1 <= full0;
    end
    if (!hold2) begin
      seg2  <= seg1;
      y2    <= xdp[18:8];
      top2  <= top1;
      bot2  <= bot1;
      ocv2  <= ocv1;
      chg2  <= chg1;
      full2 <= full1;
    end
    if (!hold3) begin
      res3.ocv_mv     <= ocv2;
      res3.percentage <= pct_out;
      res3.charging   <= chg2;
      res3.is_full    <= full2;
    end
  end

  assign out_valid  = v3;
  assign out_result = res3;

endmodule

// ----- rtl/battery_charge_gauge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_charge_gauge
// Voltage based state of charge estimate with series resistance correction.
// ----------------------------------------------------------------------------
// The gauge takes one charger sample per transaction and returns one result
// per sample, in order: the IR-corrected open-circuit voltage in mV, the
// charge percentage and the charging and full flags. It accepts a new sample
// on every clock while sample_stall is low; each result passes through a
// pipeline of 16 register stages (4 front stages, 8 divider stages at
// two quotient bits each, 4 curve stages, the first loaded at the
// accepting edge). When the result side stalls, the stages keep filling
// until the pipeline is full, and only then does sample_stall rise.
// Write configuration only while no sample is in flight; a write takes effect
// for samples accepted on the next clock or later.
// ----------------------------------------------------------------------------
module battery_charge_gauge (
  input  logic             clk,
  input  logic             rst,
  // configuration write port
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [12:0]      cfg_data,
  // sample channel
  input  logic             sample_valid,
  output logic             sample_stall,
  input  bcg_pkg::sample_t sample,
  // result channel
  output logic             result_valid,
  input  logic             result_stall,
  output bcg_pkg::result_t result
);

  // configuration registers
  logic [12:0] full_mv;
  logic [12:0] empty_mv;
  logic [9:0]  path_res;

  // window values in uV, refreshed every clock from the registers
  logic [bcg_pkg::UV_W-1:0] empty_uv;
  logic [bcg_pkg::UV_W-1:0] den_uv;
  logic                     window_ok;
  logic [12:0]              span_mv;

  bcg_pkg::gauge_cfg_t cfg;

  // front to divider
  logic                 front_valid, front_stall;
  bcg_pkg::front_item_t front_item;
  // divider to curve
  logic                 ratio_valid, ratio_stall;
  bcg_pkg::ratio_item_t ratio_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_mv  <= bcg_pkg::FULL_MV_RESET;
      empty_mv <= bcg_pkg::EMPTY_MV_RESET;
      path_res <= bcg_pkg::PATH_RES_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bcg_pkg::CFG_FULL_MV:  full_mv  <= cfg_data;
        bcg_pkg::CFG_EMPTY_MV: empty_mv <= cfg_data;
        bcg_pkg::CFG_PATH_RES: path_res <= cfg_data[9:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // span only matters when full is above empty
  assign span_mv = full_mv - empty_mv;

  always_ff @(posedge clk) begin
    empty_uv  <= bcg_pkg::UV_W'(empty_mv) * bcg_pkg::UV_W'(bcg_pkg::UV_PER_MV);
    den_uv    <= bcg_pkg::UV_W'(span_mv) * bcg_pkg::UV_W'(bcg_pkg::UV_PER_MV);
    window_ok <= full_mv > empty_mv;
  end

  // resistance is used one stage after acceptance, straight from its register
  always_comb begin
    cfg.path_res  = path_res;
    cfg.empty_uv  = empty_uv;
    cfg.den_uv    = den_uv;
    cfg.window_ok = window_ok;
  end

  // decode, IR correction, mV conversion, window compare
  bcg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .item_valid   (front_valid),
    .item_stall   (front_stall),
    .item         (front_item)
  );

  // Q0.16 ratio of the voltage inside the window
  bcg_ratio_div u_div (
    .clk       (clk),
    .rst       (rst),
    .den_uv    (den_uv),
    .in_valid  (front_valid),
    .in_stall  (front_stall),
    .in_item   (front_item),
    .out_valid (ratio_valid),
    .out_stall (ratio_stall),
    .out_item  (ratio_item)
  );

  // curve mapping and interpolation, last stage is the result register
  bcg_curve u_curve (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (ratio_valid),
    .in_stall   (ratio_stall),
    .in_item    (ratio_item),
    .out_valid  (result_valid),
    .out_stall  (result_stall),
    .out_result (result)
  );

endmodule

// ----- dv/battery_charge_gauge_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_charge_gauge_tb
// Self-checking testbench for the battery charge gauge: an in-bench predictor
// computes the corrected open-circuit voltage, the charge percentage and the
// charger flags for every accepted sample, and a checker compares each result
// transaction in order. Directed tests cover field extremes, charger status
// decode, resistance masking and saturation, and the degenerate window;
// random phases sweep register settings under sender gaps and result stalls.
// ----------------------------------------------------------------------------
module battery_charge_gauge_tb;

  localparam int CLK_HALF_NS   = 10;
  localparam int LIMIT_CYCLES  = 250000;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_PRINTS    = 40;
  localparam int PHASE_ITEMS   = 235;
  // the index that decodes to no register
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_BURSTY} stall_mode_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_write;
  logic [1:0]       cfg_index;
  logic [12:0]      cfg_data;
  logic             sample_valid;
  logic             sample_stall;
  bcg_pkg::sample_t sample;
  logic             result_valid;
  logic             result_stall;
  bcg_pkg::result_t result;

  // shadow copy of the gauge registers
  logic [12:0] cfg_full_mv;
  logic [12:0] cfg_empty_mv;
  logic [9:0]  cfg_path_res;

  // discharge curve knees, highest voltage first
  int knee_mv  [12] = '{4200, 4060, 3980, 3920, 3870, 3820, 3790, 3770, 3740, 3680,
                        3450, 3300};
  int knee_pct [12] = '{100, 90, 80, 70, 60, 50, 40, 30, 20, 10, 5, 0};

  bcg_pkg::result_t pending_results [$];
  bcg_pkg::result_t want;
  int          error_count     = 0;
  int          samples_sent    = 0;
  int          results_checked = 0;
  int          settings_used   = 0;
  int          cycle_count     = 0;

  // pacing of both channels
  stall_mode_t stall_mode  = STALL_NONE;
  int          stall_run   = 0;
  logic        stall_level = 1'b0;
  int          gap_max     = 0;
  int          burst_left  = 0;

  battery_charge_gauge uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #CLK_HALF_NS clk = ~clk;

  // timeout backstop
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // percentage from the discharge curve, input in mV with 8 fraction bits
  function automatic int curve_percent(input longint volt_q8);
    longint hi;
    longint lo;
    if (volt_q8 >= longint'(knee_mv[0]) * 256) return 100;
    if (volt_q8 <= longint'(knee_mv[11]) * 256) return 0;
    for (int k = 0; k < 11; k++) begin
      hi = longint'(knee_mv[k]) * 256;
      lo = longint'(knee_mv[k + 1]) * 256;
      if (volt_q8 <= hi && volt_q8 > lo)
        return knee_pct[k + 1] +
               int'(((volt_q8 - lo) * longint'(knee_pct[k] - knee_pct[k + 1])) / (hi - lo));
    end
    return 0;
  endfunction

  // expected result for one sample under the current register settings
  function automatic bcg_pkg::result_t gauge_estimate(input bcg_pkg::sample_t s);
    logic [11:0] vcode;
    logic [11:0] icode;
    logic [2:0]  chg;
    logic        present;
    logic        charging;
    logic        full;
    longint      ibat_ma;
    longint      ocv_uv;
    longint      ocv_mv;
    longint      num;
    longint      den;
    longint      ratio;
    longint      volt_q8;
    int          pct;
    bcg_pkg::result_t r;
    vcode    = {s.vbat_high_byte[3:0], s.vbat_low_byte};
    icode    = {s.ibat_high_byte[3:0], s.ibat_low_byte};
    chg      = s.charger_status_byte[5:3];
    present  = (s.charger_status_byte[2:0] != 3'd0) || s.charger_status_byte[6];
    charging = present && (chg == bcg_pkg::CHG_PRE || chg == bcg_pkg::CHG_CC ||
                           chg == bcg_pkg::CHG_CV);
    full     = present && (chg == bcg_pkg::CHG_DONE);

    ibat_ma = longint'($signed(icode)) * 4;
    ocv_uv  = longint'(vcode) * bcg_pkg::VBAT_UV_PER_CODE - ibat_ma * longint'(cfg_path_res);
    ocv_mv  = ocv_uv / bcg_pkg::UV_PER_MV;
    if (ocv_mv > bcg_pkg::OCV_MAX_MV) ocv_mv = bcg_pkg::OCV_MAX_MV;

    if (full) begin
      pct = 100;
    end else begin
      num = ocv_uv - longint'(cfg_empty_mv) * bcg_pkg::UV_PER_MV;
      if (cfg_full_mv > cfg_empty_mv) begin
        den = (longint'(cfg_full_mv) - longint'(cfg_empty_mv)) * bcg_pkg::UV_PER_MV;
        if (num <= 0)        ratio = 0;
        else if (num >= den) ratio = longint'(bcg_pkg::RATIO_ONE);
        else                 ratio = (num * longint'(bcg_pkg::RATIO_ONE)) / den;
      end else begin
        // empty at or above full: a step at the empty setting
        ratio = (num >= 0) ? longint'(bcg_pkg::RATIO_ONE) : 0;
      end
      volt_q8 = longint'(bcg_pkg::NORM_LOW_Q8) + ((ratio * bcg_pkg::NORM_SPAN_MV) >> 8);
      pct = curve_percent(volt_q8);
      if (charging && pct == 100) pct = 99;
    end

    r.ocv_mv     = 15'(ocv_mv);
    r.percentage = 7'(pct);
    r.charging   = charging;
    r.is_full    = full;
    return r;
  endfunction

  function automatic bcg_pkg::sample_t make_sample(input logic [11:0] vcode,
                                                   input logic [11:0] icode,
                                                   input logic [7:0] status);
    bcg_pkg::sample_t s;
    s.vbat_low_byte       = vcode[7:0];
    s.vbat_high_byte      = {4'd0, vcode[11:8]};
    s.ibat_low_byte       = icode[7:0];
    s.ibat_high_byte      = {4'd0, icode[11:8]};
    s.charger_status_byte = status;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp_val);
    if (error_count < MAX_PRINTS)
      $display("ERROR: result %0d %s: got %0d, expected %0d", results_checked, what, got,
               exp_val);
    error_count++;
  endtask

  // result checker: one transaction per edge with valid high and stall low
  always @(posedge clk) begin
    if (rst === 1'b0 && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, ocv_mv", longint'(result.ocv_mv), 0);
      end else begin
        want = pending_results.pop_front();
        if (result.ocv_mv !== want.ocv_mv)
          report_mismatch("ocv_mv", longint'(result.ocv_mv), longint'(want.ocv_mv));
        if (result.percentage !== want.percentage)
          report_mismatch("percentage", longint'(result.percentage), longint'(want.percentage));
        if (result.charging !== want.charging)
          report_mismatch("charging", longint'(result.charging), longint'(want.charging));
        if (result.is_full !== want.is_full)
          report_mismatch("is_full", longint'(result.is_full), longint'(want.is_full));
        results_checked++;
      end
    end
  end

  // result stall pattern: none, light random, or long random runs
  always @(posedge clk) begin
    case (stall_mode)
      STALL_NONE:  result_stall <= 1'b0;
      STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_run == 0) begin
          stall_level = ($urandom_range(0, 4) < 3);
          stall_run   = $urandom_range(1, 24);
        end
        stall_run--;
        result_stall <= stall_level;
      end
    endcase
  end

  // one sample transaction, then an optional gap once the burst runs out
  task automatic send_sample(input bcg_pkg::sample_t s);
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (sample_stall !== 1'b0) @(posedge clk);
    pending_results.push_back(gauge_estimate(s));
    samples_sent++;
    if (gap_max != 0) begin
      if (burst_left == 0) begin
        sample_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // hold the sender until every expected result has come back
  task automatic drain_results;
    int waited;
    waited = 0;
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      report_mismatch("results never arrived, count", 0, pending_results.size());
      pending_results.delete();
    end
  endtask

  // register write; only called with the gauge drained
  task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      bcg_pkg::CFG_FULL_MV:  cfg_full_mv  = value;
      bcg_pkg::CFG_EMPTY_MV: cfg_empty_mv = value;
      bcg_pkg::CFG_PATH_RES: cfg_path_res = value[9:0];
      default: ;
    endcase
    settings_used++;
    @(posedge clk);
  endtask

  // field extremes under the reset settings
  task automatic test_field_extremes;
    bcg_pkg::sample_t s;
    send_sample(make_sample(12'd0, 12'd0, 8'h00));
    send_sample(make_sample(12'hFFF, 12'h800, 8'h00));
    // unused upper bits set everywhere, most positive current
    s = make_sample(12'hFFF, 12'h7FF, 8'h80);
    s.vbat_high_byte = 8'hFF;
    s.ibat_high_byte = 8'hF7;
    send_sample(s);
    send_sample(make_sample(12'd2000, 12'h7FF, 8'h41));
  endtask

  // every charge state with input present, plus presence by power good alone
  task automatic test_status_decode;
    for (int c = 0; c < 8; c++)
      send_sample(make_sample(12'd2150, 12'd0, {2'b00, 3'(c), 3'd1}));
    send_sample(make_sample(12'd2150, 12'd0, {1'b0, 1'b1, bcg_pkg::CHG_DONE, 3'd0}));
    // no input: charge state is not trusted
    send_sample(make_sample(12'd2150, 12'd0, {1'b1, 1'b0, bcg_pkg::CHG_CC, 3'd0}));
  endtask

  // resistance masking, ignored index, saturation and truncation toward zero
  task automatic test_path_resistance;
    drain_results();
    write_reg(bcg_pkg::CFG_PATH_RES, 13'h1FFF);
    write_reg(CFG_UNUSED, 13'h0BAD);
    send_sample(make_sample(12'hFFF, 12'h800, 8'h00));
    send_sample(make_sample(12'd0, 12'h7FF, 8'h00));
  endtask

  // empty setting at or above the full setting
  task automatic test_degenerate_window;
    drain_results();
    write_reg(bcg_pkg::CFG_PATH_RES, 13'd0);
    write_reg(bcg_pkg::CFG_FULL_MV, 13'd3000);
    write_reg(bcg_pkg::CFG_EMPTY_MV, 13'd4500);
    send_sample(make_sample(12'd2250, 12'd0, 8'h00));
    send_sample(make_sample(12'd2249, 12'd0, 8'h00));
    drain_results();
    write_reg(bcg_pkg::CFG_EMPTY_MV, 13'd3000);
    send_sample(make_sample(12'd1500, 12'd0, 8'h00));
    send_sample(make_sample(12'd1499, 12'd0, 8'h00));
  endtask

  // one random phase at one register setting
  task automatic run_random_phase(input int full_mv, input int empty_mv, input int res_mohm,
                                  input stall_mode_t mode, input int gap);
    bcg_pkg::sample_t s;
    logic [11:0] vcode;
    logic [11:0] icode;
    int          lo_mv;
    int          hi_mv;
    drain_results();
    write_reg(bcg_pkg::CFG_FULL_MV, 13'(full_mv));
    write_reg(bcg_pkg::CFG_EMPTY_MV, 13'(empty_mv));
    write_reg(bcg_pkg::CFG_PATH_RES, 13'(res_mohm));
    stall_mode = mode;
    gap_max    = gap;
    burst_left = 0;
    lo_mv = ((full_mv < empty_mv) ? full_mv : empty_mv) - 100;
    hi_mv = ((full_mv > empty_mv) ? full_mv : empty_mv) + 100;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // mid-phase pause: let the pipeline empty completely
      if (n == PHASE_ITEMS / 2) drain_results();
      // most voltages land around the window, some anywhere
      if ($urandom_range(0, 4) == 0) vcode = 12'($urandom_range(0, 4095));
      else                           vcode = 12'($urandom_range(lo_mv / 2, hi_mv / 2));
      // mostly small currents so the corrected voltage stays near the window
      if ($urandom_range(0, 2) == 0) icode = 12'($urandom_range(0, 4095));
      else                           icode = 12'($urandom_range(0, 100) - 50);
      s.vbat_low_byte       = vcode[7:0];
      s.vbat_high_byte      = {4'($urandom_range(0, 15)), vcode[11:8]};
      s.ibat_low_byte       = icode[7:0];
      s.ibat_high_byte      = {4'($urandom_range(0, 15)), icode[11:8]};
      s.charger_status_byte = 8'($urandom_range(0, 255));
      send_sample(s);
    end
  endtask

  task automatic test_random_traffic;
    // reset settings with no idling on either side
    run_random_phase(4200, 3300, 320, STALL_NONE, 0);
    // widest window, largest in-range resistance
    run_random_phase(5000, 2500, 1000, STALL_LIGHT, 3);
    run_random_phase(3000, 4500, 0, STALL_BURSTY, 8);
    run_random_phase(4000, 4000, 500, STALL_LIGHT, 0);
    run_random_phase(3001, 3000, 1, STALL_BURSTY, 2);
    for (int p = 0; p < 3; p++)
      run_random_phase($urandom_range(3000, 5000), $urandom_range(2500, 4500),
                       $urandom_range(0, 1000), stall_mode_t'($urandom_range(0, 2)),
                       $urandom_range(0, 6));
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= bcg_pkg::CFG_FULL_MV;
    cfg_data     <= 13'd0;
    sample_valid <= 1'b0;
    sample       <= '0;
    cfg_full_mv  = bcg_pkg::FULL_MV_RESET;
    cfg_empty_mv = bcg_pkg::EMPTY_MV_RESET;
    cfg_path_res = bcg_pkg::PATH_RES_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    stall_mode = STALL_LIGHT;
    gap_max    = 2;
    test_field_extremes();
    test_status_decode();
    test_path_resistance();
    test_degenerate_window();
    test_random_traffic();

    drain_results();
    // extra cycles so a stray result would still be caught
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("summary: %0d samples sent, %0d results checked, %0d register writes",
             samples_sent, results_checked, settings_used);
    $display("summary: status decode, saturation, degenerate windows, random phases");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", error_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- battery_charge_gauge.f -----
rtl/bcg_pkg.sv
rtl/bcg_front.sv
rtl/bcg_ratio_div.sv
rtl/bcg_curve.sv
rtl/battery_charge_gauge.sv
dv/battery_charge_gauge_tb.sv
